// ===== sv/neural_activation_unit_defines.svh =====
// assertion macros shared by the activation unit rtl
`ifndef NEURAL_ACTIVATION_UNIT_DEFINES_SVH
`define NEURAL_ACTIVATION_UNIT_DEFINES_SVH
`ifndef SYNTH
`define NAU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nau assertion failed");
`define NAU_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nau assertion failed");
`else
`define NAU_ASSERT_IMP(label, clk, rst, ante, cons)
`define NAU_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/nau_pkg.sv =====
// types, constants and the divider step of the activation unit
`default_nettype none
package nau_pkg;
   localparam int QB = 30;
   localparam logic [30:0] QONE = 31'h4000_0000;
   localparam logic [29:0] LN2_Q = 30'd744261118;
   localparam logic [63:0] EXP_ZERO_LIMIT = 64'd23072094658;
   localparam logic [30:0] LAMBDA_Q = 31'd1128180534;
   localparam logic [30:0] LAMALPHA_Q = 31'd1887739361;

   localparam logic [3:0] FN_IDENTITY = 4'd0;
   localparam logic [3:0] FN_STEP     = 4'd1;
   localparam logic [3:0] FN_SIGMOID  = 4'd2;
   localparam logic [3:0] FN_TANH     = 4'd3;
   localparam logic [3:0] FN_RELU     = 4'd4;
   localparam logic [3:0] FN_SOFTPLUS = 4'd5;
   localparam logic [3:0] FN_ELU      = 4'd6;
   localparam logic [3:0] FN_SELU     = 4'd7;
   localparam logic [3:0] FN_LEAKY    = 4'd8;

   localparam logic [1:0] CSR_FSEL  = 2'd0;
   localparam logic [1:0] CSR_DERIV = 2'd1;
   localparam logic [1:0] CSR_ALPHA = 2'd2;

   localparam logic [15:0] Y_MAX = 16'h7fff;
   localparam logic [15:0] Y_MIN = 16'h8000;

   typedef struct packed {
      logic [15:0] x;
      logic        big;
      logic [4:0]  k;
      logic [34:0] rem;
   } red_type;

   typedef struct packed {
      logic [15:0]        x;
      logic               big;
      logic [4:0]         k;
      logic [29:0]        r;
      logic [30:0]        term;
      logic [59:0]        prod;
      logic signed [32:0] sum;
   } tay_type;

   typedef struct packed {
      logic [15:0] x;
      logic [30:0] e;
   } exp_type;

   typedef struct packed {
      logic [15:0] x;
      logic [30:0] e;
      logic [30:0] q1;
      logic [31:0] rem;
      logic [30:0] num;
      logic [31:0] den;
      logic [30:0] quo;
   } div_type;

   typedef struct packed {
      logic [15:0] x;
      logic [30:0] e;
      logic [30:0] q1;
      logic [29:0] s2;
      logic [29:0] term;
      logic [31:0] acc;
   } log_type;

   typedef struct packed {
      logic [15:0]        x;
      logic [30:0]        q1;
      logic [31:0]        acc;
      logic signed [63:0] prod;
   } mul_type;

   typedef struct packed {
      logic signed [63:0] v;
      logic [5:0]         sh;
      logic               forced;
   } val_type;

   typedef struct packed {
      logic signed [63:0] y;
      logic               forced;
   } rnd_type;

   // one restoring step: one quotient bit
   function automatic div_type div_step(div_type d);
      logic [32:0] trial;
      div_type     o;
      o = d;
      trial = {d.rem, d.num[30]};
      o.num = {d.num[29:0], 1'b0};
      if (trial >= {1'b0, d.den}) begin
         o.rem = 32'(trial - {1'b0, d.den});
         o.quo = {d.quo[29:0], 1'b1};
      end else begin
         o.rem = trial[31:0];
         o.quo = {d.quo[29:0], 1'b0};
      end
      return o;
   endfunction
endpackage
`default_nettype wire

// ===== sv/neural_activation_unit.sv =====
// activation unit: nine activations and their derivatives on Q4.12 samples
//
// req channel: one signed sample word per accepted handshake (req_valid & req_ready).
// rsp channel: one result word per sample, in order, with a saturation flag.
// csr port: write-only, index 0 function select, 1 derivative mode, 2 alpha.
// The user must write registers only while no sample is in flight; the block
// does not enforce this. Throughput: one sample per cycle unless rsp_ready stalls
// the pipe. Pipe depth is set by the exp range reduction (5), the 16-term series
// (2 stages a term), two 31-step restoring dividers and the 16-term log series.
// Every sample runs the full pipe whatever function is selected.
// Reset clears the pipe valids and loads function 0, value mode, alpha 1.0.
// When rsp_ready is low with a word waiting, the whole pipe holds and
// req_ready drops in the same cycle; nothing is lost or repeated.
`default_nettype none
`include "neural_activation_unit_defines.svh"
module neural_activation_unit #(
   parameter int FRAC_BITS = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_x_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_y_value,
   output logic               rsp_saturated,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [14:0]        csr_write_data
);
   import nau_pkg::*;

   localparam int SH_FR = QB - FRAC_BITS;
   localparam int AXW = 46 - FRAC_BITS;
   localparam int TW = AXW + 1;
   localparam int NSTG = 126;
   localparam int IDX_EX = 40;
   localparam int IDX_D1_LAST = 72;

   logic [3:0]  fsel_ff, fsel_in;
   logic        deriv_ff, deriv_in;
   logic [14:0] alpha_ff, alpha_in;

   logic            adv;
   logic [NSTG-1:0] vld_ff, vld_in;

   logic [15:0] x_ff;
   red_type red_ff [0:5];
   red_type red_in [0:5];
   tay_type tay_ff [0:32];
   tay_type tay_in [0:32];
   exp_type ex_ff, ex_in;
   div_type d1_ff [0:31];
   div_type d1_in [0:31];
   div_type d2_ff [0:31];
   div_type d2_in [0:31];
   log_type lg_ff [0:16];
   log_type lg_in [0:16];
   mul_type mul_ff, mul_in;
   val_type val_ff, val_in;
   rnd_type rnd_ff, rnd_in;
   logic [15:0] y_ff, y_in;
   logic        sat_ff, sat_in;

   // configuration
   always_comb begin
      fsel_in = fsel_ff;
      deriv_in = deriv_ff;
      alpha_in = alpha_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FSEL:  fsel_in = csr_write_data[3:0];
            CSR_DERIV: deriv_in = csr_write_data[0];
            CSR_ALPHA: alpha_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsel_ff <= FN_IDENTITY;
         deriv_ff <= 1'b0;
         alpha_ff <= 15'd4096;
      end else begin
         fsel_ff <= fsel_in;
         deriv_ff <= deriv_in;
         alpha_ff <= alpha_in;
      end
   end

   // global stall: whole pipe holds while the output word waits
   assign adv = !vld_ff[NSTG-1] || rsp_ready;
   assign req_ready = adv;
   assign vld_in = {vld_ff[NSTG-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // range reduction t = k*ln2 + r
   always_comb begin : red0_comb
      logic [15:0]   mag;
      logic [AXW-1:0] ax;
      logic [TW-1:0]  t;
      mag = x_ff[15] ? 16'(-x_ff) : x_ff;
      ax = AXW'(mag) << SH_FR;
      t = (fsel_ff == FN_TANH) ? {ax, 1'b0} : {1'b0, ax};
      red_in[0].x = x_ff;
      red_in[0].big = 64'(t) >= EXP_ZERO_LIMIT;
      red_in[0].k = '0;
      red_in[0].rem = red_in[0].big ? '0 : 35'(t);
   end

   for (genvar s = 0; s < 5; s++) begin : g_red
      localparam int Bit = 4 - s;
      always_comb begin
         logic [34:0] lim;
         lim = 35'(LN2_Q) << Bit;
         red_in[s+1] = red_ff[s];
         if (red_ff[s].rem >= lim) begin
            red_in[s+1].rem = red_ff[s].rem - lim;
            red_in[s+1].k[Bit] = 1'b1;
         end
      end
   end

   // exp(-r) series, a multiply stage then a divide-by-n stage per term
   always_comb begin
      tay_in[0].x = red_ff[5].x;
      tay_in[0].big = red_ff[5].big;
      tay_in[0].k = red_ff[5].k;
      tay_in[0].r = red_ff[5].rem[29:0];
      tay_in[0].term = QONE;
      tay_in[0].prod = '0;
      tay_in[0].sum = signed'(33'(QONE));
   end

   for (genvar i = 0; i < 16; i++) begin : g_tay
      localparam int unsigned DivN = i + 1;
      localparam int unsigned DivS = 30 + $clog2(DivN);
      localparam logic [63:0] Recip = ((64'd1 << DivS) + 64'(DivN) - 64'd1) / DivN;
      always_comb begin
         logic [60:0] p61;
         p61 = tay_ff[2*i].term * tay_ff[2*i].r;
         tay_in[2*i+1] = tay_ff[2*i];
         tay_in[2*i+1].prod = p61[59:0];
      end
      always_comb begin
         logic [63:0] qp;
         logic [29:0] q;
         qp = 64'(tay_ff[2*i+1].prod[59:30]) * Recip;
         q = 30'(qp >> DivS);
         tay_in[2*i+2] = tay_ff[2*i+1];
         tay_in[2*i+2].term = 31'(q);
         if (DivN % 2 == 1) begin
            tay_in[2*i+2].sum = tay_ff[2*i+1].sum - signed'(33'(q));
         end else begin
            tay_in[2*i+2].sum = tay_ff[2*i+1].sum + signed'(33'(q));
         end
      end
   end

   always_comb begin : ex_comb
      logic [30:0] pos;
      pos = tay_ff[32].sum[32] ? '0 : tay_ff[32].sum[30:0];
      ex_in.x = tay_ff[32].x;
      ex_in.e = tay_ff[32].big ? '0 : (pos >> tay_ff[32].k);
   end

   // first divider: sigmoid p or tanh magnitude
   always_comb begin : d1_setup
      logic [30:0] numer;
      logic [60:0] n61;
      numer = (fsel_ff == FN_TANH) ? (QONE - ex_ff.e) : QONE;
      n61 = {numer, 30'd0};
      d1_in[0].x = ex_ff.x;
      d1_in[0].e = ex_ff.e;
      d1_in[0].q1 = '0;
      d1_in[0].rem = 32'(n61[60:31]);
      d1_in[0].num = n61[30:0];
      d1_in[0].den = 32'(QONE) + 32'(ex_ff.e);
      d1_in[0].quo = '0;
   end

   // second divider: s = u/(2+u) for ln(1+u)
   always_comb begin : d2_setup
      logic [60:0] n61;
      n61 = {d1_ff[31].e, 30'd0};
      d2_in[0].x = d1_ff[31].x;
      d2_in[0].e = d1_ff[31].e;
      d2_in[0].q1 = d1_ff[31].quo;
      d2_in[0].rem = 32'(n61[60:31]);
      d2_in[0].num = n61[30:0];
      d2_in[0].den = 32'h8000_0000 + 32'(d1_ff[31].e);
      d2_in[0].quo = '0;
   end

   for (genvar j = 0; j < 31; j++) begin : g_div
      assign d1_in[j+1] = div_step(d1_ff[j]);
      assign d2_in[j+1] = div_step(d2_ff[j]);
   end

   // log series over odd n
   always_comb begin : lg0_comb
      logic [59:0] sq;
      sq = d2_ff[31].quo[29:0] * d2_ff[31].quo[29:0];
      lg_in[0].x = d2_ff[31].x;
      lg_in[0].e = d2_ff[31].e;
      lg_in[0].q1 = d2_ff[31].q1;
      lg_in[0].s2 = sq[59:30];
      lg_in[0].term = d2_ff[31].quo[29:0];
      lg_in[0].acc = '0;
   end

   for (genvar i = 0; i < 16; i++) begin : g_log
      localparam int unsigned DivN = 2 * i + 1;
      localparam int unsigned DivS = 30 + $clog2(DivN);
      localparam logic [63:0] Recip = ((64'd1 << DivS) + 64'(DivN) - 64'd1) / DivN;
      always_comb begin
         logic [63:0] qp;
         logic [59:0] tp;
         qp = 64'(lg_ff[i].term) * Recip;
         tp = lg_ff[i].term * lg_ff[i].s2;
         lg_in[i+1] = lg_ff[i];
         lg_in[i+1].acc = lg_ff[i].acc + 32'(qp >> DivS);
         lg_in[i+1].term = tp[59:30];
      end
   end

   // shared multiplier for the scaled cases
   always_comb begin : mul_comb
      logic signed [32:0] opa;
      logic signed [31:0] opb;
      logic signed [31:0] em1;
      logic signed [64:0] pw;
      logic               x_neg;
      x_neg = lg_ff[16].x[15];
      em1 = signed'(32'(lg_ff[16].e)) - signed'(32'(QONE));
      opa = '0;
      opb = '0;
      unique case (fsel_ff)
         FN_SIGMOID, FN_SOFTPLUS: begin
            opa = signed'(33'(lg_ff[16].q1));
            opb = signed'(32'(QONE - lg_ff[16].q1));
         end
         FN_TANH: begin
            opa = signed'(33'(lg_ff[16].q1));
            opb = signed'(32'(lg_ff[16].q1));
         end
         FN_ELU: begin
            opa = signed'(33'(alpha_ff));
            opb = deriv_ff ? signed'(32'(lg_ff[16].e)) : em1;
         end
         FN_SELU: begin
            if (x_neg) begin
               opa = signed'(33'(LAMALPHA_Q));
               opb = deriv_ff ? signed'(32'(lg_ff[16].e)) : em1;
            end else begin
               opa = signed'(33'(LAMBDA_Q));
               opb = 32'(signed'(lg_ff[16].x));
            end
         end
         FN_LEAKY: begin
            opa = signed'(33'(alpha_ff));
            opb = 32'(signed'(lg_ff[16].x));
         end
         default: ;
      endcase
      pw = opa * opb;
      mul_in.x = lg_ff[16].x;
      mul_in.q1 = lg_ff[16].q1;
      mul_in.acc = lg_ff[16].acc;
      mul_in.prod = pw[63:0];
   end

   // pick the wide value and its fraction shift
   always_comb begin : val_comb
      logic signed [63:0] xs;
      logic signed [63:0] xq;
      logic signed [63:0] one_q;
      logic signed [63:0] sig;
      logic               x_pos;
      logic               x_neg;
      xs = 64'(signed'(mul_ff.x));
      xq = xs <<< SH_FR;
      one_q = 64'sd1 <<< FRAC_BITS;
      x_neg = mul_ff.x[15];
      x_pos = !mul_ff.x[15] && (mul_ff.x != '0);
      sig = x_neg ? signed'(64'(QONE - mul_ff.q1)) : signed'(64'(mul_ff.q1));
      val_in.v = '0;
      val_in.sh = '0;
      val_in.forced = 1'b0;
      unique case (fsel_ff)
         FN_IDENTITY: val_in.v = deriv_ff ? one_q : xs;
         FN_STEP: begin
            if (deriv_ff) begin
               // infinite derivative at zero
               val_in.forced = (mul_ff.x == '0);
            end else begin
               val_in.v = x_neg ? 64'sd0 : one_q;
            end
         end
         FN_SIGMOID: begin
            val_in.sh = 6'(SH_FR);
            val_in.v = deriv_ff ? (mul_ff.prod >>> QB) : sig;
         end
         FN_SOFTPLUS: begin
            val_in.sh = 6'(SH_FR);
            val_in.v = deriv_ff ? sig
                     : ((x_pos ? xq : 64'sd0) + signed'(64'({mul_ff.acc, 1'b0})));
         end
         FN_TANH: begin
            val_in.sh = 6'(SH_FR);
            if (deriv_ff) begin
               val_in.v = signed'(64'(QONE)) - (mul_ff.prod >>> QB);
            end else begin
               val_in.v = x_neg ? -signed'(64'(mul_ff.q1)) : signed'(64'(mul_ff.q1));
            end
         end
         FN_RELU: val_in.v = x_pos ? (deriv_ff ? one_q : xs) : 64'sd0;
         FN_ELU: begin
            if (x_pos) begin
               val_in.v = deriv_ff ? one_q : xs;
            end else begin
               val_in.v = mul_ff.prod;
               val_in.sh = 6'(QB);
            end
         end
         FN_SELU: begin
            if (x_neg) begin
               val_in.v = mul_ff.prod;
               val_in.sh = 6'(2 * QB - FRAC_BITS);
            end else if (deriv_ff) begin
               val_in.v = signed'(64'(LAMBDA_Q));
               val_in.sh = 6'(SH_FR);
            end else begin
               val_in.v = mul_ff.prod;
               val_in.sh = 6'(QB);
            end
         end
         FN_LEAKY: begin
            if (x_pos) begin
               val_in.v = deriv_ff ? one_q : xs;
            end else if (deriv_ff) begin
               val_in.v = signed'(64'(alpha_ff));
            end else begin
               val_in.v = mul_ff.prod;
               val_in.sh = 6'(FRAC_BITS);
            end
         end
         default: ;
      endcase
   end

   // round to nearest, ties away from zero
   always_comb begin : rnd_comb
      logic [63:0] mag;
      logic [63:0] half;
      logic [63:0] rmag;
      mag = val_ff.v[63] ? 64'(-val_ff.v) : 64'(val_ff.v);
      half = (val_ff.sh == '0) ? 64'd0 : (64'd1 << (val_ff.sh - 6'd1));
      rmag = (mag + half) >> val_ff.sh;
      rnd_in.y = val_ff.v[63] ? -signed'(rmag) : signed'(rmag);
      rnd_in.forced = val_ff.forced;
   end

   always_comb begin
      if (rnd_ff.forced || (rnd_ff.y > 64'sd32767)) begin
         y_in = Y_MAX;
         sat_in = 1'b1;
      end else if (rnd_ff.y < -64'sd32768) begin
         y_in = Y_MIN;
         sat_in = 1'b1;
      end else begin
         y_in = rnd_ff.y[15:0];
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= req_x_value;
         red_ff <= red_in;
         tay_ff <= tay_in;
         ex_ff <= ex_in;
         d1_ff <= d1_in;
         d2_ff <= d2_in;
         lg_ff <= lg_in;
         mul_ff <= mul_in;
         val_ff <= val_in;
         rnd_ff <= rnd_in;
         y_ff <= y_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid = vld_ff[NSTG-1];
   assign rsp_y_value = signed'(y_ff);
   assign rsp_saturated = sat_ff;

   `NAU_ASSERT_NXT(a_stall_holds_pipe, clock, reset, !adv, $stable(vld_ff))
   `NAU_ASSERT_IMP(a_sat_on_rail, clock, reset, rsp_valid && rsp_saturated, (rsp_y_value == Y_MAX) || (rsp_y_value == Y_MIN))
   `NAU_ASSERT_IMP(a_exp_bounded, clock, reset, vld_ff[IDX_EX], ex_ff.e <= QONE)
   `NAU_ASSERT_IMP(a_div1_bounded, clock, reset, vld_ff[IDX_D1_LAST], d1_ff[31].quo <= QONE)
endmodule
`default_nettype wire
